>>> rtl/abs_pkg.sv
`default_nettype none
package abs_pkg;

  // input command codes
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // job kinds passed from the front to the back
  localparam logic [1:0] JOB_PKT  = 2'd0;
  localparam logic [1:0] JOB_DROP = 2'd1;
  localparam logic [1:0] JOB_STOP = 2'd2;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PSUM_W  = 13;
  localparam int unsigned INDEX_W = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic       seq;
    logic       stop_first;
  } job_t;

  function automatic logic [WORD_W-1:0] sext_byte(input logic [BYTE_W-1:0] b);
    sext_byte = {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

endpackage
`default_nettype wire

>>> rtl/abs_in_if.sv
`default_nettype none
interface abs_in_if import abs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [CMD_W-1:0]   cmd;
  logic        [BYTE_W-1:0]  msg_byte;
  logic signed [WORD_W-1:0]  pkt_seqnum;
  logic signed [WORD_W-1:0]  pkt_acknum;
  logic signed [WORD_W-1:0]  pkt_checksum;
  logic signed [PSUM_W-1:0]  pkt_payload_sum;

  modport source (
    output valid, cmd, msg_byte, pkt_seqnum, pkt_acknum, pkt_checksum, pkt_payload_sum,
    input  ready
  );
  modport sink (
    input  valid, cmd, msg_byte, pkt_seqnum, pkt_acknum, pkt_checksum, pkt_payload_sum,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/abs_out_if.sv
`default_nettype none
interface abs_out_if import abs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       pkt_valid;
  logic        [INDEX_W-1:0]  word_index;
  logic signed [WORD_W-1:0]   word_value;
  logic                       timer_start;
  logic                       timer_stop;
  logic                       dropped;
  logic                       last;

  modport source (
    output valid, pkt_valid, word_index, word_value, timer_start, timer_stop, dropped, last,
    input  ready
  );
  modport sink (
    input  valid, pkt_valid, word_index, word_value, timer_start, timer_stop, dropped, last,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/abs_store.sv
`default_nettype none
module abs_store import abs_pkg::*; #(
  parameter int unsigned SLOTS  = 20,
  parameter int unsigned SLOT_W = 5,
  parameter int unsigned POS_W  = 5,
  parameter int unsigned SUM_W  = 13
) (
  input  wire logic                     clk,
  input  wire logic                     byte_we,
  input  wire logic [SLOT_W-1:0]        byte_wslot,
  input  wire logic [POS_W-1:0]         byte_wpos,
  input  wire logic [BYTE_W-1:0]        byte_wdata,
  input  wire logic                     sum_we,
  input  wire logic [SLOT_W-1:0]        sum_wslot,
  input  wire logic signed [SUM_W-1:0]  sum_wdata,
  input  wire logic                     rd_en,
  input  wire logic [SLOT_W-1:0]        rd_slot,
  input  wire logic [POS_W-1:0]         rd_pos,
  output logic      [BYTE_W-1:0]        byte_rd_r,
  output logic signed [SUM_W-1:0]       sum_rd_r
);
  localparam int unsigned BYTE_DEPTH = SLOTS << POS_W;

  logic [BYTE_W-1:0]       byte_mem [BYTE_DEPTH];
  logic signed [SUM_W-1:0] sum_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[{byte_wslot, byte_wpos}] <= byte_wdata;
    end
    if (rd_en) begin
      byte_rd_r <= byte_mem[{rd_slot, rd_pos}];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wslot] <= sum_wdata;
    end
    if (rd_en) begin
      sum_rd_r <= sum_mem[rd_slot];
    end
  end
endmodule
`default_nettype wire

>>> rtl/abs_jobq.sv
`default_nettype none
module abs_jobq #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  logic [W-1:0] e0_r, e1_r;
  logic [1:0]   count_r;
  logic         do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = e0_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      case ({do_push, do_pop})
        2'b10: count_r <= count_r + 2'd1;
        2'b01: count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({do_push, do_pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          e0_r <= wdata;
        end else begin
          e1_r <= wdata;
        end
      end
      2'b01: e0_r <= e1_r;
      2'b11: begin
        if (count_r == 2'd1) begin
          e0_r <= wdata;
        end else begin
          e0_r <= e1_r;
          e1_r <= wdata;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/abs_front.sv
`default_nettype none
module abs_front import abs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_BYTES = 20,
  parameter int unsigned SLOTS         = 20,
  parameter int unsigned SLOT_W        = 5,
  parameter int unsigned POS_W         = 5,
  parameter int unsigned SUM_W         = 13
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  abs_in_if.sink                       in_if,
  // job push toward the back
  output logic                         job_push,
  output job_t                         job,
  output logic [SLOT_W-1:0]            job_slot,
  input  wire logic                    job_full,
  // store write side
  output logic                         byte_we,
  output logic [SLOT_W-1:0]            byte_wslot,
  output logic [POS_W-1:0]             byte_wpos,
  output logic [BYTE_W-1:0]            byte_wdata,
  output logic                         sum_we,
  output logic [SLOT_W-1:0]            sum_wslot,
  output logic signed [SUM_W-1:0]      sum_wdata
);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                    ack_r, seq_r, held_seq_r, zero_r;
  logic [SLOT_W-1:0]       head_r, asm_r;
  logic [CNT_W-1:0]        count_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [SUM_W-1:0] run_sum_r;

  logic                    accept;
  logic [BYTE_W-1:0]       eff_byte;
  logic signed [SUM_W-1:0] sum_new;
  logic                    msg_done, ack_ok;
  logic [WORD_W-1:0]       ck_calc;
  logic [SLOT_W-1:0]       head_inc, asm_inc;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign in_if.ready = !job_full;
  assign accept      = in_if.valid && !job_full;

  assign eff_byte = zero_r ? '0 : in_if.msg_byte;
  assign sum_new  = run_sum_r + SUM_W'(signed'(eff_byte));
  assign msg_done = (pos_r == POS_W'(PAYLOAD_BYTES - 1));
  assign head_inc = slot_inc(head_r);
  assign asm_inc  = slot_inc(asm_r);

  assign ck_calc = in_if.pkt_seqnum + in_if.pkt_acknum
                 + {{(WORD_W-PSUM_W){in_if.pkt_payload_sum[PSUM_W-1]}}, in_if.pkt_payload_sum};
  assign ack_ok  = !ack_r && (ck_calc == in_if.pkt_checksum)
                 && (in_if.pkt_acknum == WORD_W'(seq_r));

  assign byte_we    = accept && (in_if.cmd == CMD_BYTE);
  assign byte_wslot = asm_r;
  assign byte_wpos  = pos_r;
  assign byte_wdata = eff_byte;
  assign sum_we     = byte_we && msg_done;
  assign sum_wslot  = asm_r;
  assign sum_wdata  = sum_new;

  // classify the item and decide what job, if any, the back gets
  always_comb begin
    job_push        = 1'b0;
    job.kind        = JOB_PKT;
    job.seq         = held_seq_r;
    job.stop_first  = 1'b0;
    job_slot        = head_r;
    if (accept) begin
      unique case (in_if.cmd)
        CMD_BYTE: begin
          if (msg_done) begin
            if (ack_r) begin
              job_push = 1'b1;
              job.seq  = seq_r;
              job_slot = asm_r;
            end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              job_push = 1'b1;
              job.kind = JOB_DROP;
            end
          end
        end
        CMD_ACK: begin
          if (ack_ok) begin
            job_push = 1'b1;
            if (count_r != '0) begin
              job.seq        = !seq_r;
              job.stop_first = 1'b1;
              job_slot       = head_inc;
            end else begin
              job.kind = JOB_STOP;
            end
          end
        end
        CMD_TIMEOUT: begin
          job_push = !ack_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_r      <= 1'b1;
      seq_r      <= 1'b0;
      held_seq_r <= 1'b0;
      zero_r     <= 1'b0;
      head_r     <= '0;
      asm_r      <= SLOT_W'(1);
      count_r    <= '0;
      pos_r      <= '0;
      run_sum_r  <= '0;
    end else if (accept) begin
      unique case (in_if.cmd)
        CMD_BYTE: begin
          if (msg_done) begin
            pos_r     <= '0;
            zero_r    <= 1'b0;
            run_sum_r <= '0;
            if (ack_r) begin
              head_r     <= asm_r;
              asm_r      <= asm_inc;
              held_seq_r <= seq_r;
              ack_r      <= 1'b0;
            end else if (count_r != CNT_W'(QUEUE_DEPTH)) begin
              count_r <= count_r + 1'b1;
              asm_r   <= asm_inc;
            end
          end else begin
            pos_r     <= pos_r + 1'b1;
            run_sum_r <= sum_new;
            if (in_if.msg_byte == '0) begin
              zero_r <= 1'b1;
            end
          end
        end
        CMD_ACK: begin
          if (ack_ok) begin
            seq_r <= !seq_r;
            if (count_r != '0) begin
              head_r     <= head_inc;
              count_r    <= count_r - 1'b1;
              held_seq_r <= !seq_r;
            end else begin
              ack_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/abs_back.sv
`default_nettype none
module abs_back import abs_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 20,
  parameter int unsigned SLOT_W        = 5,
  parameter int unsigned POS_W         = 5,
  parameter int unsigned SUM_W         = 13
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // job pop from the queue
  input  wire logic                 job_empty,
  input  wire job_t                 job,
  input  wire logic [SLOT_W-1:0]    job_slot,
  output logic                      job_pop,
  // store read side
  output logic                      rd_en,
  output logic [SLOT_W-1:0]         rd_slot,
  output logic [POS_W-1:0]          rd_pos,
  input  wire logic [BYTE_W-1:0]    byte_rd,
  input  wire logic signed [SUM_W-1:0] sum_rd,
  abs_out_if.source                 out_if
);
  localparam int unsigned F_W    = $clog2(PAYLOAD_BYTES + 3);
  localparam int unsigned F_LAST = PAYLOAD_BYTES + 2;

  logic              busy_r;
  job_t              cur_r;
  logic [SLOT_W-1:0] slot_r;
  logic [F_W-1:0]    f_r;
  logic [F_W-1:0]    f_m3;

  logic              v2_r;
  job_t              job2_r;
  logic [F_W-1:0]    idx2_r;

  logic              o_valid_r, o_pkt_r, o_start_r, o_stop_r, o_drop_r, o_last_r;
  logic [INDEX_W-1:0] o_index_r;
  logic [WORD_W-1:0] o_value_r;

  logic              advance, issue_end;
  logic              w_pkt, w_start, w_stop, w_drop, w_last;
  logic [INDEX_W-1:0] w_index;
  logic [WORD_W-1:0] w_value;

  assign advance   = !o_valid_r || out_if.ready;
  assign job_pop   = !busy_r && !job_empty;
  assign issue_end = (cur_r.kind != JOB_PKT) || (f_r == F_W'(F_LAST));

  assign f_m3    = f_r - F_W'(3);
  assign rd_en   = advance && busy_r;
  assign rd_slot = slot_r;
  assign rd_pos  = f_m3[POS_W-1:0];

  // sequencer: one word issued per advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      if (job_pop) begin
        busy_r <= 1'b1;
      end else if (advance && busy_r && issue_end) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        v2_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r  <= job;
      slot_r <= job_slot;
      f_r    <= '0;
    end else if (advance && busy_r) begin
      f_r <= f_r + 1'b1;
    end
    if (advance) begin
      job2_r <= cur_r;
      idx2_r <= f_r;
    end
  end

  // form the word once the store data has landed
  always_comb begin
    w_pkt   = 1'b0;
    w_index = '0;
    w_value = '0;
    w_start = 1'b0;
    w_stop  = 1'b0;
    w_drop  = 1'b0;
    w_last  = 1'b1;
    unique case (job2_r.kind)
      JOB_PKT: begin
        w_pkt   = 1'b1;
        w_index = INDEX_W'(idx2_r);
        w_start = (idx2_r == F_W'(F_LAST));
        w_last  = w_start;
        w_stop  = job2_r.stop_first && (idx2_r == '0);
        if (idx2_r == '0) begin
          w_value = WORD_W'(job2_r.seq);
        end else if (idx2_r == F_W'(1)) begin
          w_value = '0;
        end else if (idx2_r == F_W'(2)) begin
          w_value = WORD_W'(job2_r.seq)
                  + {{(WORD_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd};
        end else begin
          w_value = sext_byte(byte_rd);
        end
      end
      JOB_DROP: w_drop = 1'b1;
      JOB_STOP: w_stop = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_pkt_r   <= w_pkt;
      o_index_r <= w_index;
      o_value_r <= w_value;
      o_start_r <= w_start;
      o_stop_r  <= w_stop;
      o_drop_r  <= w_drop;
      o_last_r  <= w_last;
    end
  end

  assign out_if.valid       = o_valid_r;
  assign out_if.pkt_valid   = o_pkt_r;
  assign out_if.word_index  = o_index_r;
  assign out_if.word_value  = o_value_r;
  assign out_if.timer_start = o_start_r;
  assign out_if.timer_stop  = o_stop_r;
  assign out_if.dropped     = o_drop_r;
  assign out_if.last        = o_last_r;
endmodule
`default_nettype wire

>>> rtl/alternating_bit_sender_top.sv
`default_nettype none
// An item reaches the output via the job queue, the back's job and stage-two registers
// and the output register. Message bytes are taken one per cycle; a packet streams out
// as PAYLOAD_BYTES+3 words, one per cycle while the output is ready, then the next job.
// Input is held off only while the two-entry job queue between front and back is full.
// Reset: synchronous, active low; control state clears at once, no clearing pass.
module alternating_bit_sender_top import abs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_BYTES = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  abs_in_if.sink    in_if,
  abs_out_if.source out_if
);
  // The store keeps four slots beyond the queue: one held packet, one being
  // assembled, and two for packets still owned by jobs in flight, so an
  // assembly never lands on a slot the back is still reading.
  localparam int unsigned SLOTS  = QUEUE_DEPTH + 4;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned POS_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int unsigned SUM_W  = BYTE_W + $clog2(PAYLOAD_BYTES);
  localparam int unsigned JOB_W  = $bits(job_t) + SLOT_W;

  // front -> job queue
  logic              job_push, job_full;
  job_t              job_in;
  logic [SLOT_W-1:0] slot_in;

  // job queue -> back
  logic              job_pop, job_empty;
  logic [JOB_W-1:0]  jq_rdata;
  job_t              job_out;
  logic [SLOT_W-1:0] slot_out;

  // store ports
  logic                    byte_we, sum_we, rd_en;
  logic [SLOT_W-1:0]       byte_wslot, sum_wslot, rd_slot;
  logic [POS_W-1:0]        byte_wpos, rd_pos;
  logic [BYTE_W-1:0]       byte_wdata, byte_rd;
  logic signed [SUM_W-1:0] sum_wdata, sum_rd;

  assign job_out  = jq_rdata[JOB_W-1 -: $bits(job_t)];
  assign slot_out = jq_rdata[SLOT_W-1:0];

  // Classify items, assemble messages into the store, track the window state
  abs_front #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .SLOTS        (SLOTS),
    .SLOT_W       (SLOT_W),
    .POS_W        (POS_W),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .job_push  (job_push),
    .job       (job_in),
    .job_slot  (slot_in),
    .job_full  (job_full),
    .byte_we   (byte_we),
    .byte_wslot(byte_wslot),
    .byte_wpos (byte_wpos),
    .byte_wdata(byte_wdata),
    .sum_we    (sum_we),
    .sum_wslot (sum_wslot),
    .sum_wdata (sum_wdata)
  );

  // Hold pending jobs so the front keeps taking items while a packet streams
  abs_jobq #(
    .W(JOB_W)
  ) u_jobq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .wdata({job_in, slot_in}),
    .full (job_full),
    .pop  (job_pop),
    .empty(job_empty),
    .rdata(jq_rdata)
  );

  // Message bytes and per-message byte sums, one write and one read port
  abs_store #(
    .SLOTS (SLOTS),
    .SLOT_W(SLOT_W),
    .POS_W (POS_W),
    .SUM_W (SUM_W)
  ) u_store (
    .clk       (clk),
    .byte_we   (byte_we),
    .byte_wslot(byte_wslot),
    .byte_wpos (byte_wpos),
    .byte_wdata(byte_wdata),
    .sum_we    (sum_we),
    .sum_wslot (sum_wslot),
    .sum_wdata (sum_wdata),
    .rd_en     (rd_en),
    .rd_slot   (rd_slot),
    .rd_pos    (rd_pos),
    .byte_rd_r (byte_rd),
    .sum_rd_r  (sum_rd)
  );

  // Stream each job out as packet words or a single status item
  abs_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .SLOT_W       (SLOT_W),
    .POS_W        (POS_W),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job      (job_out),
    .job_slot (slot_out),
    .job_pop  (job_pop),
    .rd_en    (rd_en),
    .rd_slot  (rd_slot),
    .rd_pos   (rd_pos),
    .byte_rd  (byte_rd),
    .sum_rd   (sum_rd),
    .out_if   (out_if)
  );
endmodule
`default_nettype wire

>>> tb/alternating_bit_sender_top_tb.sv
`timescale 1ns / 100ps

module alternating_bit_sender_top_tb;
  import abs_pkg::*;

  localparam int unsigned PAYLOAD_LEN      = 20;
  localparam int unsigned SEND_QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS     = 45;
  localparam int unsigned MAX_REPORTS      = 100;

  // The fourth command code has no meaning; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] msg_t;

  // One item on the input channel.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] msg_byte;
    logic [WORD_W-1:0] seqnum;
    logic [WORD_W-1:0] acknum;
    logic [WORD_W-1:0] checksum;
    logic [PSUM_W-1:0] payload_sum;
  } sender_cmd_t;

  // One item on the result channel.
  typedef struct packed {
    logic               pkt_valid;
    logic [INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]  word_value;
    logic               timer_start;
    logic               timer_stop;
    logic               dropped;
    logic               last;
  } pkt_word_t;

  logic clk = 1'b0;
  logic rst_n;

  abs_in_if  in_if ();
  abs_out_if out_if ();

  alternating_bit_sender_top #(
    .QUEUE_DEPTH  (SEND_QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_LEN)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender state as the block should hold it.
  // ---------------------------------------------------------------------------
  logic        link_idle;      // previous packet acknowledged, nothing in flight
  logic        seq_bit;
  msg_t        held_msg;
  logic        held_seq;
  logic [31:0] held_sum;
  msg_t        pend_msgs [SEND_QUEUE_DEPTH];
  int unsigned pend_head, pend_tail, pend_count;
  int unsigned fill_pos;
  logic        zero_fill;
  msg_t        asm_msg;

  pkt_word_t   expected_words [$];

  // Run control and tallies.
  bit          idle_on;
  int unsigned items_applied;
  int unsigned words_checked, packets_seen, drops_seen, stops_seen;
  int unsigned mismatches;

  function automatic void reset_sender_state();
    link_idle  = 1'b1;
    seq_bit    = 1'b0;
    held_msg   = '0;
    held_seq   = 1'b0;
    held_sum   = '0;
    pend_head  = 0;
    pend_tail  = 0;
    pend_count = 0;
    fill_pos   = 0;
    zero_fill  = 1'b0;
    asm_msg    = '0;
  endfunction

  function automatic pkt_word_t make_word(input logic v, input logic [INDEX_W-1:0] idx,
                                          input logic [WORD_W-1:0] val, input logic tstart,
                                          input logic tstop, input logic drop,
                                          input logic fin);
    pkt_word_t w;
    w.pkt_valid   = v;
    w.word_index  = idx;
    w.word_value  = val;
    w.timer_start = tstart;
    w.timer_stop  = tstop;
    w.dropped     = drop;
    w.last        = fin;
    return w;
  endfunction

  // Latch a message as the packet in flight and compute its checksum.
  function automatic void hold_message(input msg_t m);
    logic [31:0] sum;
    sum = {31'b0, seq_bit};
    for (int i = 0; i < PAYLOAD_LEN; i++)
      sum += {{(WORD_W-BYTE_W){m[i][BYTE_W-1]}}, m[i]};
    held_msg  = m;
    held_seq  = seq_bit;
    held_sum  = sum;
    link_idle = 1'b0;
  endfunction

  // Expect the held packet word by word: seq, ack, checksum, payload.
  function automatic void expect_packet(input logic stop_first);
    logic fin;
    expected_words.push_back(make_word(1'b1, INDEX_W'(0), {31'b0, held_seq},
                                       1'b0, stop_first, 1'b0, 1'b0));
    expected_words.push_back(make_word(1'b1, INDEX_W'(1), '0,
                                       1'b0, 1'b0, 1'b0, 1'b0));
    expected_words.push_back(make_word(1'b1, INDEX_W'(2), held_sum,
                                       1'b0, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      fin = (i == PAYLOAD_LEN - 1);
      expected_words.push_back(make_word(1'b1, INDEX_W'(i + 3),
                                         {{(WORD_W-BYTE_W){held_msg[i][BYTE_W-1]}}, held_msg[i]},
                                         fin, 1'b0, 1'b0, fin));
    end
  endfunction

  // Advance the sender state by one accepted item; return 1 if the item mattered.
  function automatic bit apply_sender_cmd(input sender_cmd_t it);
    logic [BYTE_W-1:0] b;
    logic [WORD_W-1:0] psum;
    bit                useful;
    useful = 1'b0;
    case (it.cmd)
      CMD_BYTE: begin
        useful = 1'b1;
        b = zero_fill ? '0 : it.msg_byte;
        if (it.msg_byte == '0)
          zero_fill = 1'b1;
        asm_msg[fill_pos] = b;
        fill_pos++;
        if (fill_pos == PAYLOAD_LEN) begin
          fill_pos  = 0;
          zero_fill = 1'b0;
          if (link_idle) begin
            hold_message(asm_msg);
            expect_packet(1'b0);
          end else if (pend_count < SEND_QUEUE_DEPTH) begin
            pend_msgs[pend_tail] = asm_msg;
            pend_tail = (pend_tail + 1) % SEND_QUEUE_DEPTH;
            pend_count++;
          end else begin
            expected_words.push_back(make_word(1'b0, INDEX_W'(0), '0,
                                               1'b0, 1'b0, 1'b1, 1'b1));
          end
        end
      end
      CMD_ACK: begin
        psum = {{(WORD_W-PSUM_W){it.payload_sum[PSUM_W-1]}}, it.payload_sum};
        if (!link_idle && (it.seqnum + it.acknum + psum) == it.checksum
            && it.acknum == {31'b0, seq_bit}) begin
          useful  = 1'b1;
          seq_bit = ~seq_bit;
          if (pend_count != 0) begin
            hold_message(pend_msgs[pend_head]);
            pend_head = (pend_head + 1) % SEND_QUEUE_DEPTH;
            pend_count--;
            expect_packet(1'b1);
          end else begin
            link_idle = 1'b1;
            expected_words.push_back(make_word(1'b0, INDEX_W'(0), '0,
                                               1'b0, 1'b1, 1'b0, 1'b1));
          end
        end
      end
      CMD_TIMEOUT: begin
        if (!link_idle) begin
          useful = 1'b1;
          expect_packet(1'b0);
        end
      end
      default: ;
    endcase
    return useful;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fill every field at random so unused fields still toggle.
  function automatic sender_cmd_t random_fields(input logic [CMD_W-1:0] code);
    sender_cmd_t it;
    it.cmd         = code;
    it.msg_byte    = BYTE_W'($urandom_range(0, 255));
    it.seqnum      = $urandom;
    it.acknum      = $urandom;
    it.checksum    = $urandom;
    it.payload_sum = PSUM_W'($urandom_range(0, 5100) - 2560);
    return it;
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_cmd(input sender_cmd_t it);
    // drop valid for a burst now and then
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.cmd             <= it.cmd;
    in_if.msg_byte        <= it.msg_byte;
    in_if.pkt_seqnum      <= it.seqnum;
    in_if.pkt_acknum      <= it.acknum;
    in_if.pkt_checksum    <= it.checksum;
    in_if.pkt_payload_sum <= it.payload_sum;
    @(posedge clk);
    while (in_if.ready !== 1'b1)
      @(posedge clk);
    if (apply_sender_cmd(it))
      items_applied++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    sender_cmd_t it;
    it = random_fields(CMD_BYTE);
    it.msg_byte = b;
    send_cmd(it);
  endtask

  // Build an ack with a consistent checksum; flip one checksum bit to corrupt it.
  task automatic send_ack(input logic [WORD_W-1:0] ak, input bit corrupt);
    sender_cmd_t it;
    it = random_fields(CMD_ACK);
    it.acknum   = ak;
    it.checksum = it.seqnum + ak
                + {{(WORD_W-PSUM_W){it.payload_sum[PSUM_W-1]}}, it.payload_sum};
    if (corrupt)
      it.checksum ^= WORD_W'(1) << $urandom_range(0, WORD_W - 1);
    send_cmd(it);
  endtask

  // Nonzero random bytes, with a zero at zero_at (negative means none).
  task automatic send_message(input int zero_at);
    for (int i = 0; i < PAYLOAD_LEN; i++)
      send_byte(i == zero_at ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Nothing in flight: ack, timeout and the unused code must all be ignored.
  task automatic test_idle_commands();
    send_ack({31'b0, seq_bit}, 1'b0);
    send_cmd(random_fields(CMD_TIMEOUT));
    send_cmd(random_fields(CMD_UNUSED));
  endtask

  // Most negative payload, then every way an ack can be rejected, a resend,
  // and a good ack with nothing queued. Then the most positive payload and a
  // good ack, so the sequence bit goes 0 -> 1 -> 0.
  task automatic test_extreme_payloads_and_acks();
    for (int i = 0; i < PAYLOAD_LEN; i++)
      send_byte(8'h80);
    send_ack({31'b0, seq_bit}, 1'b1);        // corrupted
    send_ack({31'b0, ~seq_bit}, 1'b0);       // wrong sequence bit
    send_ack(32'h8000_0000, 1'b0);           // far off sequence value
    send_cmd(random_fields(CMD_TIMEOUT));    // resend the held packet
    send_cmd(random_fields(CMD_UNUSED));
    send_ack({31'b0, seq_bit}, 1'b0);        // good ack, queue empty
    send_ack({31'b0, seq_bit}, 1'b0);        // now idle again: ignored
    for (int i = 0; i < PAYLOAD_LEN; i++)
      send_byte(8'h7F);
    send_ack({31'b0, seq_bit}, 1'b0);
  endtask

  // A zero byte mid-message forces the rest of the payload to zero; leave
  // the packet unacknowledged so the next two messages wait in the queue.
  task automatic test_zero_fill();
    send_message(7);
    send_cmd(random_fields(CMD_TIMEOUT));
    send_message(0);                         // queued behind the first
    send_message(PAYLOAD_LEN - 1);
  endtask

  // Drain the two queued messages with good acks, with a stale ack, a
  // resend and a corrupted ack in between, then stop the timer.
  task automatic test_queue_drain();
    send_ack({31'b0, ~seq_bit}, 1'b0);       // stale: ignored
    send_ack({31'b0, seq_bit}, 1'b0);        // first queued message goes out
    send_cmd(random_fields(CMD_TIMEOUT));
    send_ack({31'b0, seq_bit}, 1'b0);        // second queued message goes out
    send_ack({31'b0, seq_bit}, 1'b1);        // corrupted
    send_ack({31'b0, seq_bit}, 1'b0);        // queue empty: timer stops
  endtask

  // Mostly whole messages and good acks, with rejected acks, resends and
  // stray codes mixed in. Idling switches on and off in stretches and is
  // off for the final stretch.
  task automatic test_random_traffic(input int unsigned target);
    int unsigned start, done, pick;
    start = items_applied;
    done  = 0;
    while (done < target) begin
      if (done + 15 >= target)
        idle_on = 1'b0;
      else if ($urandom_range(0, 24) == 0)
        idle_on = ~idle_on;
      pick = $urandom_range(0, 99);
      if ((fill_pos != 0 && pick < 90) || pick < 40)
        send_byte(($urandom_range(0, 19) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
      else if (pick < 70)
        send_ack(link_idle ? $urandom : {31'b0, seq_bit}, 1'b0);
      else if (pick < 80)
        send_cmd(random_fields(CMD_TIMEOUT));
      else if (pick < 86)
        send_ack({31'b0, seq_bit}, 1'b1);
      else if (pick < 92)
        send_ack($urandom_range(0, 1) ? {31'b0, ~seq_bit} : $urandom, 1'b0);
      else
        send_cmd(random_fields(CMD_UNUSED));
      done = items_applied - start;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall ready in bursts, check each accepted item.
  // ---------------------------------------------------------------------------
  int unsigned sink_hold = 0;

  always @(posedge clk) begin
    if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_hold == 1) begin
      sink_hold    <= 0;
      out_if.ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_hold    <= $urandom_range(1, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    pkt_word_t got, want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = make_word(out_if.pkt_valid, out_if.word_index, out_if.word_value,
                      out_if.timer_start, out_if.timer_stop, out_if.dropped, out_if.last);
      words_checked++;
      if (got.timer_start === 1'b1) packets_seen++;
      if (got.dropped === 1'b1)     drops_seen++;
      if (got.timer_stop === 1'b1)  stops_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual v=%b i=%0d val=%h",
                   $time, got.pkt_valid, got.word_index, got.word_value);
          $display("%0t:   actual start=%b stop=%b drop=%b last=%b",
                   $time, got.timer_start, got.timer_stop, got.dropped, got.last);
        end
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected v=%b i=%0d val=%h start=%b stop=%b drop=%b last=%b",
                     $time, want.pkt_valid, want.word_index, want.word_value,
                     want.timer_start, want.timer_stop, want.dropped, want.last);
            $display("%0t: actual   v=%b i=%0d val=%h start=%b stop=%b drop=%b last=%b",
                     $time, got.pkt_valid, got.word_index, got.word_value,
                     got.timer_start, got.timer_stop, got.dropped, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero.
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.cmd             <= CMD_BYTE;
    in_if.msg_byte        <= '0;
    in_if.pkt_seqnum      <= '0;
    in_if.pkt_acknum      <= '0;
    in_if.pkt_checksum    <= '0;
    in_if.pkt_payload_sum <= '0;
    idle_on       = 1'b1;
    items_applied = 0;
    words_checked = 0;
    packets_seen  = 0;
    drops_seen    = 0;
    stops_seen    = 0;
    mismatches    = 0;
    reset_sender_state();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    test_extreme_payloads_and_acks();
    test_zero_fill();
    test_queue_drain();
    test_random_traffic(RANDOM_ITEMS);

    // Release valid on the step of the last accept, then drain.
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Covered %0d useful input items: %0d packets sent or resent, %0d messages dropped,",
             items_applied, packets_seen, drops_seen);
    $display("%0d timer stops; %0d result words checked, %0d mismatches.",
             stops_seen, words_checked, mismatches);
    if (mismatches == 0)
      $display("alternating_bit_sender_top_tb: PASS");
    else
      $display("alternating_bit_sender_top_tb: FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d results still expected.", expected_words.size());
    $display("alternating_bit_sender_top_tb: FAIL");
    $finish;
  end

endmodule
